// ----- src/xt256_pkg.sv -----
`timescale 1ns / 1ps
// shared types, palette constants and distance helpers for the xterm 256 nearest-color core
// no dependencies; imported by every module of the block

package xt256_pkg;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_INDEX = 2'd1;
	localparam logic [1:0] MODE_TRUE  = 2'd2;

	localparam logic [4:0] GREY_LAST = 5'd23;

	localparam logic [23:0] SYS_COLORS [16] = '{
		24'h000000, 24'h800000, 24'h008000, 24'h808000,
		24'h000080, 24'h800080, 24'h008080, 24'hc0c0c0,
		24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
		24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
	};

	localparam logic [7:0] CUBE_LEVELS [6] = '{
		8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff
	};

	// stage advance enables, one per register stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} xt_adv_t;

	typedef struct packed {
		logic [2:0] lvl;
		logic [7:0] gap;
	} xt_cube_pick_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [9:0] dist3(input logic [23:0] a, input logic [23:0] b);
		return {2'b00, absdiff8(a[23:16], b[23:16])}
			+ {2'b00, absdiff8(a[15:8], b[15:8])}
			+ {2'b00, absdiff8(a[7:0], b[7:0])};
	endfunction

	// nearest cube level of one channel, lowest level on ties
	function automatic xt_cube_pick_t cube_pick(input logic [7:0] x);
		xt_cube_pick_t p;
		logic [7:0] d;
		p.lvl = 3'd0;
		p.gap = absdiff8(x, CUBE_LEVELS[0]);
		for (int i = 1; i < 6; i++) begin
			d = absdiff8(x, CUBE_LEVELS[i]);
			if (d < p.gap) begin
				p.gap = d;
				p.lvl = 3'(i);
			end
		end
		return p;
	endfunction

endpackage

// ----- src/xt256_sys_nearest.sv -----
`timescale 1ns / 1ps
// three-stage search over the 16 system colors: distances, 16-to-4 reduce, 4-to-1 reduce
// depends on xt256_pkg

module xt256_sys_nearest import xt256_pkg::*; (
	input  logic        clk,
	input  xt_adv_t     adv,
	input  logic [23:0] rgb,
	output logic [9:0]  dist_s3,
	output logic [3:0]  idx_s3
);

	logic [9:0] dist_s1 [16];
	logic [9:0] dist_s2 [4];
	logic [3:0] idx_s2 [4];
	logic [9:0] grp_dist [4];
	logic [3:0] grp_idx [4];
	logic [9:0] fin_dist;
	logic [3:0] fin_idx;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			for (int i = 0; i < 16; i++) begin
				dist_s1[i] <= dist3(rgb, SYS_COLORS[i]);
			end
		end
	end

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			grp_dist[g] = dist_s1[g * 4];
			grp_idx[g] = 4'(g * 4);
			for (int j = 1; j < 4; j++) begin
				if (dist_s1[g * 4 + j] < grp_dist[g]) begin
					grp_dist[g] = dist_s1[g * 4 + j];
					grp_idx[g] = 4'(g * 4 + j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int g = 0; g < 4; g++) begin
				dist_s2[g] <= grp_dist[g];
				idx_s2[g] <= grp_idx[g];
			end
		end
	end

	always_comb begin
		fin_dist = dist_s2[0];
		fin_idx = idx_s2[0];
		for (int g = 1; g < 4; g++) begin
			if (dist_s2[g] < fin_dist) begin
				fin_dist = dist_s2[g];
				fin_idx = idx_s2[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			dist_s3 <= fin_dist;
			idx_s3 <= fin_idx;
		end
	end

endmodule

// ----- src/xt256_cube_grey.sv -----
`timescale 1ns / 1ps
// three-stage nearest search over the 6x6x6 cube (per channel) and the 24-step grey ramp (median)
// depends on xt256_pkg

module xt256_cube_grey import xt256_pkg::*; (
	input  logic        clk,
	input  xt_adv_t     adv,
	input  logic [23:0] rgb,
	output logic [9:0]  cube_dist_s3,
	output logic [7:0]  cube_idx_s3,
	output logic [9:0]  grey_dist_s3,
	output logic [7:0]  grey_idx_s3
);

	xt_cube_pick_t pick_r_s1, pick_g_s1, pick_b_s1;
	logic [7:0]  med_s1;
	logic [23:0] rgb_s1;
	logic [7:0]  lo_rg, hi_rg, med;

	logic [9:0]  cube_dist_s2;
	logic [7:0]  cube_idx_s2;
	logic [4:0]  k0_s2;
	logic [23:0] rgb_s2;
	logic [15:0] prod;
	logic [4:0]  kq, k0;
	logic [7:0]  cidx;

	logic [7:0]  v0, v1;
	logic [9:0]  d0, d1;
	logic [4:0]  ksel;
	logic [9:0]  dsel;

	// stage 1: per-channel cube level and median of the three channels
	always_comb begin
		lo_rg = (rgb[23:16] < rgb[15:8]) ? rgb[23:16] : rgb[15:8];
		hi_rg = (rgb[23:16] < rgb[15:8]) ? rgb[15:8] : rgb[23:16];
		med = (hi_rg < rgb[7:0]) ? hi_rg : rgb[7:0];
		if (lo_rg > med) begin
			med = lo_rg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			pick_r_s1 <= cube_pick(rgb[23:16]);
			pick_g_s1 <= cube_pick(rgb[15:8]);
			pick_b_s1 <= cube_pick(rgb[7:0]);
			med_s1 <= med;
			rgb_s1 <= rgb;
		end
	end

	// stage 2: cube index and distance, grey step at or just below the median (first step if the median is below it)
	always_comb begin
		cidx = 8'd16 + 8'({5'd0, pick_r_s1.lvl} * 8'd36)
			+ 8'({5'd0, pick_g_s1.lvl} * 8'd6) + {5'd0, pick_b_s1.lvl};
		prod = {8'd0, med_s1 - 8'd8} * 16'd205;
		kq = prod[15:11];
		if (med_s1 < 8'd8) begin
			k0 = 5'd0;
		end else if (kq > GREY_LAST) begin
			k0 = GREY_LAST;
		end else begin
			k0 = kq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			cube_idx_s2 <= cidx;
			cube_dist_s2 <= {2'b00, pick_r_s1.gap} + {2'b00, pick_g_s1.gap}
				+ {2'b00, pick_b_s1.gap};
			k0_s2 <= k0;
			rgb_s2 <= rgb_s1;
		end
	end

	// stage 3: the two grey steps around the median, lower step on ties
	always_comb begin
		v0 = 8'd8 + 8'({3'd0, k0_s2} * 8'd10);
		v1 = v0 + 8'd10;
		d0 = dist3(rgb_s2, {v0, v0, v0});
		d1 = dist3(rgb_s2, {v1, v1, v1});
		ksel = k0_s2;
		dsel = d0;
		if (k0_s2 != GREY_LAST && d1 < d0) begin
			ksel = k0_s2 + 5'd1;
			dsel = d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			cube_dist_s3 <= cube_dist_s2;
			cube_idx_s3 <= cube_idx_s2;
			grey_dist_s3 <= dsel;
			grey_idx_s3 <= 8'd232 + {3'd0, ksel};
		end
	end

endmodule

// ----- src/rgb_to_xterm256_nearest_core.sv -----
`timescale 1ns / 1ps
// top level of the xterm 256 nearest-color core: mode register, valid chain, final select
// depends on xt256_pkg, xt256_sys_nearest, xt256_cube_grey
//
// usage:
//   input channel  in_valid/in_stall carries color_word and layer; a transfer with a zero
//   top byte, or with the mode off or unused, is taken and gives no result
//   output channel out_valid/out_stall carries layer_out, is_true_color, palette_index,
//   red, green, blue; palette mode zeroes red/green/blue, true mode zeroes palette_index
//   cfg_valid/cfg_ready writes the mode register from cfg_data; cfg_ready is always high;
//   write only while no transfer is in flight
// timing:
//   an input transfer passes four register stages (distance, reduce, reduce, final compare),
//   the last of which drives out_valid; one transfer per cycle sustained while out_stall is low
// reset:
//   arst_n clears all valid bits and sets the mode register to off
// back-pressure:
//   each stage holds while the one after it is full and held, so empty stages keep
//   filling; in_stall rises only when all four stages hold data and out_stall is high

module rgb_to_xterm256_nearest_core import xt256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] color_word,
	input  logic        layer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        layer_out,
	output logic        is_true_color,
	output logic [7:0]  palette_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	logic [1:0] mode_q;
	xt_adv_t    adv;
	logic       take;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic layer_s1, layer_s2, layer_s3;
	logic true_s1, true_s2, true_s3;
	logic [23:0] rgb_s1, rgb_s2, rgb_s3;

	logic [9:0] sys_dist_s3, cube_dist_s3, grey_dist_s3;
	logic [3:0] sys_idx_s3;
	logic [7:0] cube_idx_s3, grey_idx_s3;
	logic [9:0] best_dist;
	logic [7:0] best_idx;

	logic       layer_q, true_q;
	logic [7:0] index_q, red_q, green_q, blue_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_comb begin
		adv.s4 = !out_valid_q || !out_stall;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_stall = !adv.s1;
	assign take = in_valid && (color_word[31:24] != 8'd0)
		&& (mode_q == MODE_INDEX || mode_q == MODE_TRUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= take;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (adv.s3) begin
				v_s3 <= v_s2;
			end
			if (adv.s4) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			layer_s1 <= layer;
			true_s1 <= (mode_q == MODE_TRUE);
			rgb_s1 <= color_word[23:0];
		end
		if (adv.s2) begin
			layer_s2 <= layer_s1;
			true_s2 <= true_s1;
			rgb_s2 <= rgb_s1;
		end
		if (adv.s3) begin
			layer_s3 <= layer_s2;
			true_s3 <= true_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	xt256_sys_nearest u_sys (
		.clk     (clk),
		.adv     (adv),
		.rgb     (color_word[23:0]),
		.dist_s3 (sys_dist_s3),
		.idx_s3  (sys_idx_s3)
	);

	xt256_cube_grey u_cube_grey (
		.clk          (clk),
		.adv          (adv),
		.rgb          (color_word[23:0]),
		.cube_dist_s3 (cube_dist_s3),
		.cube_idx_s3  (cube_idx_s3),
		.grey_dist_s3 (grey_dist_s3),
		.grey_idx_s3  (grey_idx_s3)
	);

	// lower index range wins ties
	always_comb begin
		best_dist = sys_dist_s3;
		best_idx = {4'd0, sys_idx_s3};
		if (cube_dist_s3 < best_dist) begin
			best_dist = cube_dist_s3;
			best_idx = cube_idx_s3;
		end
		if (grey_dist_s3 < best_dist) begin
			best_dist = grey_dist_s3;
			best_idx = grey_idx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			layer_q <= layer_s3;
			true_q <= true_s3;
			index_q <= true_s3 ? 8'd0 : best_idx;
			red_q <= true_s3 ? rgb_s3[23:16] : 8'd0;
			green_q <= true_s3 ? rgb_s3[15:8] : 8'd0;
			blue_q <= true_s3 ? rgb_s3[7:0] : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign layer_out = layer_q;
	assign is_true_color = true_q;
	assign palette_index = index_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline stage");

	a_true_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_true_color) |-> (palette_index == 8'd0))
		else $error("true color result carries a palette index");

	a_index_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_true_color) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("palette result carries color bytes");
`endif

endmodule
